[hdl/hbpwm_pkg.sv]
// Shared types, codes and constants for the H-bridge PWM drive.
// Used by hbpwm_step and the top level; depends on nothing else.
package hbpwm_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_DIR   = 2'd1,
    OP_SPEED = 2'd2,
    OP_ECHO  = 2'd3
  } op_e;

  localparam logic [2:0] CMD_STOP  = 3'd0;
  localparam logic [2:0] CMD_FWD   = 3'd1;
  localparam logic [2:0] CMD_LEFT  = 3'd2;
  localparam logic [2:0] CMD_RIGHT = 3'd3;
  localparam logic [2:0] CMD_BACK  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OBSTACLE = 2'd2;
  localparam logic [1:0] ST_LINK     = 2'd3;

  localparam logic [1:0] REG_PERIOD   = 2'd0;
  localparam logic [1:0] REG_ECHO_MIN = 2'd1;
  localparam logic [1:0] REG_ECHO_MAX = 2'd2;

  localparam logic [15:0] PERIOD_RESET   = 16'd20000;
  localparam logic [14:0] ECHO_MIN_RESET = 15'd117;
  localparam logic [14:0] ECHO_MAX_RESET = 15'd1457;
  localparam logic [14:0] ECHO_TIMEOUT   = 15'd30000;
  localparam logic [6:0]  PCT_FULL       = 7'd100;

  // floor(x / 100) = (x * DIV100_MUL) >> DIV100_SHIFT, exact for x below 14M
  localparam int          PROD_W       = 23;
  localparam int          RECIP_W      = 24;
  localparam int          DIV100_SHIFT = 30;
  localparam logic [RECIP_W-1:0] DIV100_MUL = 24'd10737419;

  typedef struct packed {
    logic [2:0]  direction;
    logic        drive_en;
    logic [6:0]  speed;
    logic [2:0]  obst;
    logic        on_phase;
    logic [15:0] remaining;
  } drive_state_t;

  typedef struct packed {
    op_e               op;
    logic [2:0]        command;
    logic [6:0]        speed;
    logic [1:0]        sensor;
    logic [14:0]       echo_us;
    logic              link_up;
    logic [PROD_W-1:0] on_prod;   // speed * period, divided by 100 downstream
  } exec_item_t;

  typedef struct packed {
    logic [3:0] bridge_pins;
    logic       pwm_en;
    logic [2:0] obstacle_flags;
    logic [2:0] direction;
    logic [1:0] status;
  } drive_result_t;

  function automatic logic [3:0] pins_of(logic [2:0] dir);
    logic [3:0] p;
    case (dir)
      CMD_FWD:   p = 4'd5;
      CMD_LEFT:  p = 4'd9;
      CMD_RIGHT: p = 4'd6;
      CMD_BACK:  p = 4'd10;
      default:   p = 4'd0;
    endcase
    return p;
  endfunction

endpackage

[hdl/hbridge_pwm_drive_with_obstacle_stop_top.sv]
// Top level of the two-motor H-bridge drive with PWM enable and obstacle stop.
// Depends on hbpwm_pkg and hbpwm_step.

// Takes one item per clock when the output is not stalled; returns one result
// item per input item, in order, via the input and result registers. The
// input register also latches speed * period for the item (using the speed
// of the item ahead of it when that one is a speed set); the execute stage
// divides that by 100 through a reciprocal multiply, updates the drive state
// and loads the result register, so that multiply sets the clock period.
// The input side keeps taking items while a result waits, until both the
// input and result registers are full. Configuration takes effect at once.
module hbridge_pwm_drive_with_obstacle_stop_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], speed_percent[9:3], sensor[11:10], echo_us[26:12],
  // link_up[27], zeros above
  input  logic [31:0] s_axis_tdata,
  // op[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // bridge_pins[3:0], pwm_en[4], obstacle_flags[7:5], direction[10:8],
  // status[12:11], zeros above
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import hbpwm_pkg::*;

  logic [15:0]   period_q;
  logic [14:0]   echo_min_q;
  logic [14:0]   echo_max_q;
  drive_state_t  state_q;
  drive_state_t  state_d;
  logic          s1_valid_q;
  exec_item_t    s1_q;
  exec_item_t    s1_d;
  logic          out_valid_q;
  drive_result_t out_q;
  drive_result_t res_d;
  logic          s1_adv;
  logic [15:0]   period_eff;
  logic [6:0]    in_speed;
  logic [6:0]    fwd_speed;

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign period_eff    = (period_q == '0) ? 16'd1 : period_q;
  assign in_speed      = (s_axis_tdata[9:3] > PCT_FULL) ? PCT_FULL : s_axis_tdata[9:3];

  // speed the item will see when it executes
  assign fwd_speed = (s1_valid_q && s1_q.op == OP_SPEED) ? s1_q.speed : state_q.speed;

  always_comb begin
    s1_d.op      = op_e'(s_axis_tuser);
    s1_d.command = s_axis_tdata[2:0];
    s1_d.speed   = in_speed;
    s1_d.sensor  = s_axis_tdata[11:10];
    s1_d.echo_us = s_axis_tdata[26:12];
    s1_d.link_up = s_axis_tdata[27];
    s1_d.on_prod = {16'b0, (op_e'(s_axis_tuser) == OP_SPEED) ? in_speed : fwd_speed} *
                   {7'b0, period_eff};
  end

  hbpwm_step u_step (
    .state_i    (state_q),
    .item_i     (s1_q),
    .period_i   (period_eff),
    .echo_min_i (echo_min_q),
    .echo_max_i (echo_max_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= PERIOD_RESET;
      echo_min_q <= ECHO_MIN_RESET;
      echo_max_q <= ECHO_MAX_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PERIOD:   period_q   <= cfg_data_i;
        REG_ECHO_MIN: echo_min_q <= cfg_data_i[14:0];
        REG_ECHO_MAX: echo_max_q <= cfg_data_i[14:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_q.status, out_q.direction, out_q.obstacle_flags,
                          out_q.pwm_en, out_q.bridge_pins};

`ifndef NO_ASSERTIONS
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.drive_en |-> (state_q.remaining == '0 && !state_q.on_phase))
    else $error("drive disabled with PWM phase still live");

  a_enable_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.pwm_en) |-> (out_q.direction != CMD_STOP))
    else $error("enable pin high while stopped");

  a_stop_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != ST_OK) |->
      (out_q.direction == CMD_STOP && !out_q.pwm_en && out_q.bridge_pins == '0))
    else $error("stop status without a stopped drive");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("input stage lost an item while stalled");
`endif

endmodule

[hdl/hbpwm_step.sv]
// Execute stage of the drive: next state and result for one item.
// Purely combinational; depends on hbpwm_pkg.
module hbpwm_step (
  input  hbpwm_pkg::drive_state_t  state_i,
  input  hbpwm_pkg::exec_item_t    item_i,
  input  logic [15:0]              period_i,
  input  logic [14:0]              echo_min_i,
  input  logic [14:0]              echo_max_i,
  output hbpwm_pkg::drive_state_t  state_o,
  output hbpwm_pkg::drive_result_t result_o
);
  import hbpwm_pkg::*;

  logic [PROD_W+RECIP_W-1:0] quot_full;
  logic [15:0]               on_len;
  logic [15:0]               off_len;
  logic                      running;
  logic                      hit;
  logic [2:0]                obst_mask;
  drive_state_t              nxt;
  logic [1:0]                status;

  // returns {on, length}; a zero-length phase is skipped
  function automatic logic [16:0] enter_phase(logic on, logic [15:0] t_on,
                                              logic [15:0] t_off);
    logic [16:0] r;
    if (on) begin
      r = (t_on == '0) ? {1'b0, t_off} : {1'b1, t_on};
    end else begin
      r = (t_off == '0) ? {1'b1, t_on} : {1'b0, t_off};
    end
    return r;
  endfunction

  function automatic drive_state_t stop_drive(drive_state_t s);
    drive_state_t r;
    r = s;
    r.direction = CMD_STOP;
    r.drive_en  = 1'b0;
    r.on_phase  = 1'b0;
    r.remaining = '0;
    return r;
  endfunction

  assign quot_full = {{RECIP_W{1'b0}}, item_i.on_prod} * {{PROD_W{1'b0}}, DIV100_MUL};
  assign on_len    = quot_full[DIV100_SHIFT +: 16];
  assign off_len   = period_i - on_len;
  assign running   = state_i.drive_en && (state_i.speed != '0);
  assign hit       = (item_i.echo_us != '0) && (item_i.echo_us <= ECHO_TIMEOUT) &&
                     (item_i.echo_us >= echo_min_i) && (item_i.echo_us <= echo_max_i);
  assign obst_mask = 3'b001 << item_i.sensor;

  always_comb begin
    nxt    = state_i;
    status = ST_OK;
    case (item_i.op)
      OP_TICK: begin
        if (running) begin
          if (state_i.remaining > 16'd1) begin
            nxt.remaining = state_i.remaining - 16'd1;
          end else begin
            {nxt.on_phase, nxt.remaining} = enter_phase(!state_i.on_phase, on_len, off_len);
          end
        end
      end
      OP_DIR: begin
        if (item_i.command == CMD_STOP) begin
          nxt = stop_drive(state_i);
        end else if (!item_i.link_up) begin
          nxt    = stop_drive(state_i);
          status = ST_LINK;
        end else if (item_i.command == CMD_FWD && state_i.obst != '0) begin
          nxt    = stop_drive(state_i);
          status = ST_OBSTACLE;
        end else if (item_i.command <= CMD_BACK) begin
          nxt.direction = item_i.command;
          nxt.drive_en  = 1'b1;
          if (state_i.speed != '0) begin
            {nxt.on_phase, nxt.remaining} = enter_phase(1'b1, on_len, off_len);
          end
        end else begin
          nxt    = stop_drive(state_i);
          status = ST_INVALID;
        end
      end
      OP_SPEED: begin
        nxt.speed = item_i.speed;
        if (item_i.speed == '0) begin
          nxt       = stop_drive(state_i);
          nxt.speed = '0;
        end else if (state_i.drive_en) begin
          {nxt.on_phase, nxt.remaining} = enter_phase(1'b1, on_len, off_len);
        end
      end
      OP_ECHO: begin
        // sensor code 3 gives an empty mask and leaves the flags alone
        nxt.obst = hit ? (state_i.obst | obst_mask) : (state_i.obst & ~obst_mask);
        if (running) begin
          if (nxt.obst != '0 && state_i.direction == CMD_FWD) begin
            nxt    = stop_drive(nxt);
            status = ST_OBSTACLE;
          end
          if (!item_i.link_up) begin
            nxt    = stop_drive(nxt);
            status = ST_LINK;
          end
        end
      end
      default: begin
        nxt = state_i;
      end
    endcase
  end

  assign state_o                 = nxt;
  assign result_o.bridge_pins    = pins_of(nxt.direction);
  assign result_o.pwm_en         = nxt.drive_en && (nxt.speed != '0) && nxt.on_phase;
  assign result_o.obstacle_flags = nxt.obst;
  assign result_o.direction      = nxt.direction;
  assign result_o.status         = status;

endmodule
